// ===== rtl/edge_list_line_parser_unit_macros.svh =====
// assertion macros for the edge list line parser
// used by the top level only, no other dependencies
`ifndef EDGE_LIST_LINE_PARSER_UNIT_MACROS_SVH
`define EDGE_LIST_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ELP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define ELP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/elp_pkg.sv =====
// types, codes and character constants of the edge list line parser
// no dependencies
package elp_pkg;

   localparam int ID_BITS_DEF = 32;
   localparam int OUT_ID_BITS = 32;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_END  = 3'd1,
      ERR_ID   = 3'd2,
      ERR_SEP  = 3'd3,
      ERR_EOL  = 3'd4
   } err_type;

   typedef enum logic [5:0] {
      PH_LINE    = 6'b000001,
      PH_COMMENT = 6'b000010,
      PH_SRC     = 6'b000100,
      PH_SEP     = 6'b001000,
      PH_TGT     = 6'b010000,
      PH_TRAIL   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                   edge_valid;
      logic [OUT_ID_BITS-1:0] source_id;
      logic [OUT_ID_BITS-1:0] target_id;
      logic [2:0]             error_code;
      logic                   done_res;
   } rsp_type;

endpackage

// ===== rtl/edge_list_line_parser_unit.sv =====
// edge list line parser, top level
// depends on elp_pkg and edge_list_line_parser_unit_macros.svh

// Parses edge-list text one byte per cycle: a byte is taken on every cycle
// in which req_valid is high and req_stall is low, and its result (if any)
// is registered on the next cycle, in the result register or, while a
// stalled result still holds that register, in the skid entry behind it.
// A result is produced
// when a line completes an edge, when the first error is raised, and on the
// byte flagged last. The first error is sticky until reset; afterwards only
// the last byte yields a result, carrying the held code with done_res set.
// The rate is one byte per cycle, set by the single phase machine and the
// shared multiply-by-ten accumulator; a one-entry skid behind the result
// register keeps input flowing while a result waits, and req_stall rises
// only once that skid entry is also occupied. Ids saturate at 2^ID_BITS-1
// and again at 2^32-1 on the result fields.
module edge_list_line_parser_unit #(
   parameter int ID_BITS = elp_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  elp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output elp_pkg::rsp_type rsp_data
);

   import elp_pkg::*;

`include "edge_list_line_parser_unit_macros.svh"

   localparam int ACC_BITS = ID_BITS + 4;
   localparam int EXT_BITS = (ID_BITS > OUT_ID_BITS) ? ID_BITS : OUT_ID_BITS + 1;

   phase_type            phase_ff, phase_in;
   logic [ID_BITS-1:0]   src_ff, src_in;
   logic [ID_BITS-1:0]   tgt_ff, tgt_in;
   logic                 err_latched_ff, err_latched_in;
   err_type              err_held_ff, err_held_in;

   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              skid_ff, skid_in;
   logic                 skid_vld_ff, skid_vld_in;

   logic                 req_accept;
   logic [7:0]           ch;
   logic                 fin;
   logic                 is_blank, is_digit, is_eol;
   logic [ID_BITS-1:0]   acc_base;
   logic [ACC_BITS-1:0]  acc_wide;
   logic [ID_BITS-1:0]   acc_step;
   logic [EXT_BITS-1:0]  src_ext, tgt_ext;
   logic [OUT_ID_BITS-1:0] src_out, tgt_out;
   logic                 edge_hit, line_closed, new_err;
   err_type              err;
   rsp_type              res;
   logic                 res_vld;
   logic                 out_free;

   assign req_stall  = skid_vld_ff;
   assign req_accept = req_valid && !req_stall;
   assign ch         = req_data.byte_req;
   assign fin        = req_data.last;

   assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_eol   = (ch == CH_LF) || (ch == CH_CR);

   // one shared acc*10+d; a fresh id starts from zero
   always_comb begin
      case (phase_ff)
         PH_SRC:  acc_base = src_ff;
         PH_TGT:  acc_base = tgt_ff;
         default: acc_base = '0;
      endcase
   end

   assign acc_wide = (ACC_BITS'(acc_base) << 3) + (ACC_BITS'(acc_base) << 1)
                   + ACC_BITS'(ch[3:0]);
   assign acc_step = (|acc_wide[ACC_BITS-1:ID_BITS]) ? {ID_BITS{1'b1}}
                                                    : acc_wide[ID_BITS-1:0];

   // clamp to the 32-bit result fields
   assign src_ext = EXT_BITS'(src_ff);
   assign tgt_ext = EXT_BITS'(tgt_ff);
   assign src_out = (|src_ext[EXT_BITS-1:OUT_ID_BITS]) ? {OUT_ID_BITS{1'b1}}
                                                      : src_ext[OUT_ID_BITS-1:0];
   assign tgt_out = (|tgt_ext[EXT_BITS-1:OUT_ID_BITS]) ? {OUT_ID_BITS{1'b1}}
                                                      : tgt_ext[OUT_ID_BITS-1:0];

   always_comb begin
      phase_in       = phase_ff;
      src_in         = src_ff;
      tgt_in         = tgt_ff;
      err_latched_in = err_latched_ff;
      err_held_in    = err_held_ff;
      edge_hit       = 1'b0;
      line_closed    = 1'b0;
      new_err        = 1'b0;
      err            = ERR_NONE;

      if (req_accept && !err_latched_ff) begin
         case (phase_ff)
            PH_LINE: begin
               if (is_blank) begin
               end else if (ch == CH_LF) begin
                  line_closed = 1'b1;
               end else if (ch == CH_HASH) begin
                  phase_in = PH_COMMENT;
               end else if (is_digit) begin
                  src_in   = acc_step;
                  phase_in = PH_SRC;
               end else begin
                  err = ERR_ID;
               end
            end
            PH_COMMENT: begin
               if (ch == CH_LF) begin
                  phase_in    = PH_LINE;
                  line_closed = 1'b1;
               end
            end
            PH_SRC: begin
               if (is_digit) begin
                  src_in = acc_step;
               end else if (is_blank) begin
                  phase_in = PH_SEP;
               end else begin
                  err = ERR_SEP;
               end
            end
            PH_SEP: begin
               if (is_blank) begin
               end else if (is_digit) begin
                  tgt_in   = acc_step;
                  phase_in = PH_TGT;
               end else begin
                  err = ERR_ID;
               end
            end
            PH_TGT, PH_TRAIL: begin
               if ((phase_ff == PH_TGT) && is_digit) begin
                  tgt_in = acc_step;
               end else if (is_blank) begin
                  phase_in = PH_TRAIL;
               end else if (is_eol) begin
                  edge_hit    = 1'b1;
                  line_closed = 1'b1;
                  phase_in    = PH_LINE;
               end else begin
                  err = ERR_EOL;
               end
            end
            default: begin
               phase_in = PH_LINE;
               err      = ERR_ID;
            end
         endcase

         // last byte must close a line
         if ((err == ERR_NONE) && fin && !line_closed) begin
            err = ERR_END;
         end
         if (err != ERR_NONE) begin
            edge_hit       = 1'b0;
            err_latched_in = 1'b1;
            err_held_in    = err;
            new_err        = 1'b1;
         end
      end

      if (req_accept && fin && !err_latched_in) begin
         phase_in = PH_LINE;
      end

      res_vld        = req_accept && (edge_hit || new_err || fin);
      res.edge_valid = edge_hit;
      res.source_id  = edge_hit ? src_out : '0;
      res.target_id  = edge_hit ? tgt_out : '0;
      res.error_code = err_latched_in ? err_held_in : ERR_NONE;
      res.done_res   = fin;
   end

   // result register with one skid entry behind it
   assign out_free = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         rsp_vld_in  = skid_vld_ff || res_vld;
         rsp_in      = skid_vld_ff ? skid_ff : res;
         skid_vld_in = 1'b0;
      end else if (res_vld) begin
         skid_vld_in = 1'b1;
         skid_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         src_ff         <= '0;
         tgt_ff         <= '0;
         err_latched_ff <= 1'b0;
         err_held_ff    <= ERR_NONE;
         rsp_vld_ff     <= 1'b0;
         skid_vld_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         src_ff         <= src_in;
         tgt_ff         <= tgt_in;
         err_latched_ff <= err_latched_in;
         err_held_ff    <= err_held_in;
         rsp_vld_ff     <= rsp_vld_in;
         skid_vld_ff    <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `ELP_ASSERT_NOW(a_skid_behind_rsp, clock, reset, skid_vld_ff, rsp_vld_ff, "skid holds a transfer while result register is empty")
   `ELP_ASSERT_NOW(a_edge_no_error, clock, reset, rsp_vld_ff && rsp_ff.edge_valid, rsp_ff.error_code == ERR_NONE, "edge reported together with an error code")
   `ELP_ASSERT_NEXT(a_error_sticky, clock, reset, err_latched_ff, err_latched_ff && $stable(err_held_ff), "latched error changed before reset")
   `ELP_ASSERT_NEXT(a_stall_fills_skid, clock, reset, req_accept && rsp_vld_ff && rsp_stall && res_vld, skid_vld_ff, "stalled result not kept in skid entry")

endmodule
